### rtl/core/tmf_pkg.sv
// shared constants and types for the trimmed mean filter
`default_nettype none

package tmf_pkg;

	localparam int SAMPLE_W = 12;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd10;
	localparam int MIN_WINDOW = 5;
	localparam int TRIM_TOTAL = 4;
	localparam int MAX_WINDOW_DEFAULT = 64;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [4:0] {
		BK_IDLE   = 5'b00001,
		BK_SUB_LO = 5'b00010,
		BK_SUB_HI = 5'b00100,
		BK_DIV    = 5'b01000,
		BK_OUT    = 5'b10000
	} back_state_t;

endpackage

`default_nettype wire

### rtl/core/tmf_sample_if.sv
// sample input channel
`default_nettype none

interface tmf_sample_if;
	logic                          valid;
	logic                          ready;
	logic [tmf_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

### rtl/core/tmf_result_if.sv
// trimmed mean result channel
`default_nettype none

interface tmf_result_if;
	logic                          valid;
	logic                          ready;
	logic [tmf_pkg::SAMPLE_W-1:0] trimmed_mean;

	modport source (output valid, output trimmed_mean, input ready);
	modport sink (input valid, input trimmed_mean, output ready);
endinterface

`default_nettype wire

### rtl/core/tmf_front.sv
// front part: window register, running sum and two lowest / two highest tracking
`default_nettype none

module tmf_front #(
	parameter int MAX_WINDOW = tmf_pkg::MAX_WINDOW_DEFAULT,
	localparam int CW = $clog2(MAX_WINDOW + 1),
	localparam int SW = tmf_pkg::SAMPLE_W + CW,
	localparam int ENTRY_W = SW + 4 * tmf_pkg::SAMPLE_W + CW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tmf_pkg::CFG_W-1:0] cfg_wdata,
	tmf_sample_if.sink                sample_ch,
	input  tmf_pkg::q_status_t        q_stat,
	output logic                      push,
	output logic [ENTRY_W-1:0]        push_data
);
	import tmf_pkg::*;

	localparam int EW = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0]    window_count_q;
	logic [SW-1:0]       sum_q;
	logic [SAMPLE_W-1:0] lo1_q, lo2_q, hi1_q, hi2_q;
	logic [CW-1:0]       cnt_q;

	logic [EW-1:0]       wc_ext, n_ext;
	logic [CW-1:0]       win_n;
	logic [SW-1:0]       sum_nx;
	logic [SAMPLE_W-1:0] lo1_nx, lo2_nx, hi1_nx, hi2_nx;
	logic [CW-1:0]       cnt_nx;
	logic                accept, done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_count_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_count_q <= cfg_wdata;
		end
	end

	// clamp the window register into the supported range
	always_comb begin
		wc_ext = EW'(window_count_q);
		priority if (wc_ext < EW'(MIN_WINDOW)) begin
			n_ext = EW'(MIN_WINDOW);
		end else if (wc_ext > EW'(MAX_WINDOW)) begin
			n_ext = EW'(MAX_WINDOW);
		end else begin
			n_ext = wc_ext;
		end
		win_n = CW'(n_ext);
	end

	assign sample_ch.ready = !q_stat.full;
	assign accept = sample_ch.valid && sample_ch.ready;

	always_comb begin
		sum_nx = sum_q + SW'(sample_ch.sample);

		priority if (sample_ch.sample < lo1_q) begin
			lo1_nx = sample_ch.sample;
			lo2_nx = lo1_q;
		end else if (sample_ch.sample < lo2_q) begin
			lo1_nx = lo1_q;
			lo2_nx = sample_ch.sample;
		end else begin
			lo1_nx = lo1_q;
			lo2_nx = lo2_q;
		end

		priority if (sample_ch.sample > hi1_q) begin
			hi1_nx = sample_ch.sample;
			hi2_nx = hi1_q;
		end else if (sample_ch.sample > hi2_q) begin
			hi1_nx = hi1_q;
			hi2_nx = sample_ch.sample;
		end else begin
			hi1_nx = hi1_q;
			hi2_nx = hi2_q;
		end

		cnt_nx = cnt_q + CW'(1);
		// a shrunk window closes on the next item
		done = (cnt_nx >= win_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			lo1_q <= '1;
			lo2_q <= '1;
			hi1_q <= '0;
			hi2_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (done) begin
				sum_q <= '0;
				lo1_q <= '1;
				lo2_q <= '1;
				hi1_q <= '0;
				hi2_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				lo1_q <= lo1_nx;
				lo2_q <= lo2_nx;
				hi1_q <= hi1_nx;
				hi2_q <= hi2_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

	assign push = accept && done;
	assign push_data = {sum_nx, lo1_nx, lo2_nx, hi1_nx, hi2_nx,
		cnt_nx - CW'(TRIM_TOTAL)};

endmodule

`default_nettype wire

### rtl/core/tmf_fifo.sv
// short queue of finished windows between front and back
`default_nettype none

module tmf_fifo #(
	parameter int W = 8,
	parameter int DEPTH = tmf_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [W-1:0]       push_data,
	input  logic               pop,
	output logic [W-1:0]       pop_data,
	output tmf_pkg::q_status_t q_stat
);
	import tmf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_stat.full = (count_q == NW'(DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

`default_nettype wire

### rtl/core/tmf_back.sv
// back part: trims the extremes and divides, one quotient bit per cycle
`default_nettype none

module tmf_back #(
	parameter int MAX_WINDOW = tmf_pkg::MAX_WINDOW_DEFAULT,
	localparam int CW = $clog2(MAX_WINDOW + 1),
	localparam int SW = tmf_pkg::SAMPLE_W + CW,
	localparam int ENTRY_W = SW + 4 * tmf_pkg::SAMPLE_W + CW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tmf_pkg::q_status_t q_stat,
	input  logic [ENTRY_W-1:0] pop_data,
	output logic               pop,
	tmf_result_if.source       result_ch
);
	import tmf_pkg::*;

	localparam int STEP_W = $clog2(SAMPLE_W);

	back_state_t         state_q;
	logic [SW-1:0]       acc_q;
	logic [SAMPLE_W-1:0] lo1_q, lo2_q, hi1_q, hi2_q;
	logic [CW-1:0]       div_q;
	logic [CW-1:0]       rem_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic [STEP_W-1:0]   step_q;

	logic [SW-1:0]       in_sum;
	logic [SAMPLE_W-1:0] in_lo1, in_lo2, in_hi1, in_hi2;
	logic [CW-1:0]       in_div;
	logic [SW-1:0]       trimmed;
	logic [CW:0]         trial, diff;
	logic                ge;

	assign {in_sum, in_lo1, in_lo2, in_hi1, in_hi2, in_div} = pop_data;
	assign pop = (state_q == BK_IDLE) && !q_stat.empty;

	assign trimmed = acc_q - SW'(hi1_q) - SW'(hi2_q);
	assign trial = {rem_q, quo_q[SAMPLE_W-1]};
	assign diff = trial - {1'b0, div_q};
	assign ge = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (pop) state_q <= BK_SUB_LO;
				end
				BK_SUB_LO: state_q <= BK_SUB_HI;
				BK_SUB_HI: begin
					state_q <= BK_DIV;
					step_q <= '0;
				end
				BK_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SAMPLE_W - 1)) state_q <= BK_OUT;
				end
				BK_OUT: begin
					if (result_ch.ready) state_q <= BK_IDLE;
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					acc_q <= in_sum;
					lo1_q <= in_lo1;
					lo2_q <= in_lo2;
					hi1_q <= in_hi1;
					hi2_q <= in_hi2;
					div_q <= in_div;
				end
			end
			BK_SUB_LO: acc_q <= acc_q - SW'(lo1_q) - SW'(lo2_q);
			BK_SUB_HI: begin
				// quotient fits in a sample, so the upper part starts below the divisor
				rem_q <= trimmed[SW-1:SAMPLE_W];
				quo_q <= trimmed[SAMPLE_W-1:0];
			end
			BK_DIV: begin
				rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
				quo_q <= {quo_q[SAMPLE_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign result_ch.valid = (state_q == BK_OUT);
	assign result_ch.trimmed_mean = quo_q;

endmodule

`default_nettype wire

### rtl/core/trimmed_mean_filter.sv
// a closing item enters the queue when accepted; the back part pops it and runs
// SUB_LO, SUB_HI, DIV and OUT, a window at a time (two trim subtractions, then the
// divider retiring one quotient bit per cycle); input takes one sample per cycle,
// but a 2-entry queue absorbs short windows and stalls the input when both are full
// reset: arst_n clears the window, queue and back state; window_count resets to 10
`default_nettype none

module trimmed_mean_filter #(
	parameter int MAX_WINDOW = tmf_pkg::MAX_WINDOW_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tmf_pkg::CFG_W-1:0] cfg_wdata,
	tmf_sample_if.sink                sample_ch,
	tmf_result_if.source              result_ch
);
	import tmf_pkg::*;

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int SW = SAMPLE_W + CW;
	localparam int ENTRY_W = SW + 4 * SAMPLE_W + CW;

	q_status_t          q_stat;
	logic               push, pop;
	logic [ENTRY_W-1:0] push_data, pop_data;

	tmf_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	tmf_fifo #(.W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	tmf_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.result_ch (result_ch)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("window pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from an empty queue");

	a_status_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.ready) |=> !result_ch.valid)
		else $error("back part produced results on consecutive cycles");

endmodule

`default_nettype wire
